>>> src/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing hash table.
// ---------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS      = 1024;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int CNT_BITS   = $clog2(SLOTS + 1);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int ENTRY_BITS = 2 + KEY_BITS + VALUE_BITS;
  localparam int OP_BITS    = 3;
  localparam int STAT_BITS  = 2;
  localparam int MAXU_BITS  = 10;
  localparam int RANK_BITS  = 11;
  localparam logic [MAXU_BITS-1:0] MAX_USED_RESET = MAXU_BITS'(512);

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_FIND     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_RETRIEVE = 3'd4
  } op_t;

  localparam logic [STAT_BITS-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_MATCH = 2'd1,
    K_TOMB  = 2'd2,
    K_OPEN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic start;
    logic clr_write;
    logic probe_chk;
    logic apply;
    logic scan_rd;
    logic scan_chk;
    logic result_simple;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic probe_done;
    logic scan_hit;
    logic rank_ok;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

>>> src/lpht_ram.sv
// ---------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lpht_ctrl.sv
// ---------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: clearing pass, probe walk, rank scan, update and result hand-off.
// ---------------------------------------------------------------------------
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_READ, S_CHECK, S_APPLY,
    S_CLEAR, S_SCAN_RD, S_SCAN_CHK, S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_INSERT, OP_REMOVE, OP_FIND: state_next = S_READ;
          OP_CLEAR: state_next = S_CLEAR;
          OP_RETRIEVE: begin
            if (sts.rank_ok) begin
              state_next = S_SCAN_RD;
            end else begin
              cmd.result_simple = 1'b1;
              state_next        = S_EMIT;
            end
          end
          default: begin
            cmd.result_simple = 1'b1;
            state_next        = S_EMIT;
          end
        endcase
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.probe_chk = 1'b1;
        state_next    = sts.probe_done ? S_APPLY : S_READ;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_EMIT;
      end
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          cmd.result_simple = 1'b1;
          state_next        = S_EMIT;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = sts.scan_hit ? S_EMIT : S_SCAN_RD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

>>> src/lpht_dp.sv
// ---------------------------------------------------------------------------
// lpht_dp
// Datapath: slot store, request and probe registers, counters, result and
// output registers.
// ---------------------------------------------------------------------------
module lpht_dp
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [MAXU_BITS-1:0]  cfg_data,
  input  logic [OP_BITS-1:0]    op,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [SLOT_BITS-1:0]  home,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RANK_BITS-1:0]  rank,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_BITS-1:0]  status,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] found_value,
  output logic [KEY_BITS-1:0]   found_key,
  output logic [SLOT_BITS-1:0]  slot,
  output logic [CNT_BITS-1:0]   live_count
);

  // request
  op_t                   req_op;
  logic [KEY_BITS-1:0]   req_key;
  logic [SLOT_BITS-1:0]  req_home;
  logic [VALUE_BITS-1:0] req_value;
  logic [RANK_BITS-1:0]  req_rank;

  // probe / scan
  logic [SLOT_BITS-1:0]  pos, steps, tomb, chosen, idx, clr_addr;
  logic                  have_tomb;
  kind_t                 kind;
  logic [VALUE_BITS-1:0] old_val;
  logic [CNT_BITS-1:0]   seen, used, live;
  logic [MAXU_BITS-1:0]  max_used;

  // result
  logic [STAT_BITS-1:0]  res_status;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_fv;
  logic [KEY_BITS-1:0]   res_fk;
  logic [SLOT_BITS-1:0]  res_slot;

  // store
  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, rdata;

  logic                  rd_occ, rd_live, key_eq, new_tomb, last_step;
  logic [VALUE_BITS-1:0] rd_val;
  logic [KEY_BITS-1:0]   rd_key;
  logic [CNT_BITS-1:0]   seen_inc, used_inc;
  logic                  room;

  assign rd_occ    = rdata[ENTRY_BITS-1];
  assign rd_live   = rdata[ENTRY_BITS-2];
  assign rd_key    = rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rd_val    = rdata[VALUE_BITS-1:0];
  assign key_eq    = rd_live && (rd_key == req_key);
  assign new_tomb  = rd_occ && !rd_live && !have_tomb;
  assign last_step = (steps == SLOT_BITS'(SLOTS - 1));
  assign seen_inc  = seen + CNT_BITS'(1);
  assign used_inc  = used + CNT_BITS'(1);
  assign room      = (used_inc <= CNT_BITS'(max_used));

  lpht_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign ram_raddr = cmd.scan_rd ? idx : pos;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chosen;
    ram_wdata = {1'b1, 1'b1, req_key, req_value};
    if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (cmd.apply) begin
      case (req_op)
        OP_INSERT: ram_we = (kind == K_MATCH) || (kind == K_TOMB) ||
                            ((kind == K_OPEN) && room);
        OP_REMOVE: begin
          ram_we    = (kind == K_MATCH);
          ram_wdata = {1'b1, 1'b0, req_key, old_val};
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    sts.op         = req_op;
    sts.probe_done = !rd_occ || key_eq || last_step;
    sts.scan_hit   = rd_occ && rd_live && (seen_inc == CNT_BITS'(req_rank));
    sts.rank_ok    = (req_rank != '0) && (req_rank <= RANK_BITS'(live));
    sts.clr_last   = (clr_addr == SLOT_BITS'(SLOTS - 1));
    sts.out_free   = !out_valid || !out_stall;
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      max_used <= MAX_USED_RESET;
      used     <= '0;
      live     <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_we) max_used <= cfg_data;
      if (cmd.clr_write) begin
        used     <= '0;
        live     <= '0;
        clr_addr <= sts.clr_last ? '0 : clr_addr + SLOT_BITS'(1);
      end else if (cmd.apply) begin
        case (req_op)
          OP_INSERT: begin
            if (kind == K_TOMB) begin
              live <= live + CNT_BITS'(1);
            end else if ((kind == K_OPEN) && room) begin
              live <= live + CNT_BITS'(1);
              used <= used_inc;
            end
          end
          OP_REMOVE: if (kind == K_MATCH) live <= live - CNT_BITS'(1);
          default: ;
        endcase
      end
    end
  end

  // request, probe walk and rank scan
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op    <= op_t'(op);
      req_key   <= key;
      req_home  <= home;
      req_value <= value;
      req_rank  <= rank;
      pos       <= home;
      steps     <= '0;
      have_tomb <= 1'b0;
      tomb      <= '0;
      idx       <= '0;
      seen      <= '0;
    end
    if (cmd.probe_chk) begin
      old_val <= rd_val;
      if (!rd_occ) begin
        kind   <= have_tomb ? K_TOMB : K_OPEN;
        chosen <= have_tomb ? tomb : pos;
      end else if (key_eq) begin
        kind   <= K_MATCH;
        chosen <= pos;
      end else begin
        if (new_tomb) begin
          have_tomb <= 1'b1;
          tomb      <= pos;
        end
        // walk bound reached: fall back to the first tombstone or home
        if (last_step) begin
          kind   <= (have_tomb || new_tomb) ? K_TOMB : K_NONE;
          chosen <= have_tomb ? tomb : (new_tomb ? pos : req_home);
        end
        pos   <= (pos == SLOT_BITS'(SLOTS - 1)) ? '0 : pos + SLOT_BITS'(1);
        steps <= steps + SLOT_BITS'(1);
      end
    end
    if (cmd.scan_chk && rd_occ && rd_live) begin
      seen <= seen_inc;
    end
    if (cmd.scan_chk) begin
      idx <= idx + SLOT_BITS'(1);
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.result_simple) begin
      res_status <= (req_op == OP_CLEAR) ? ST_DONE : ST_MISS;
      res_hit    <= 1'b0;
      res_fv     <= '0;
      res_fk     <= req_key;
      res_slot   <= '0;
    end else if (cmd.scan_chk) begin
      res_status <= ST_DONE;
      res_hit    <= 1'b0;
      res_fv     <= rd_val;
      res_fk     <= rd_key;
      res_slot   <= idx;
    end else if (cmd.apply) begin
      res_fk   <= req_key;
      res_slot <= chosen;
      res_hit  <= (kind == K_MATCH);
      res_fv   <= (kind == K_MATCH) ? old_val : '0;
      case (req_op)
        OP_INSERT: begin
          if ((kind == K_MATCH) || (kind == K_TOMB) || ((kind == K_OPEN) && room)) begin
            res_status <= ST_DONE;
          end else begin
            res_status <= ST_FULL;
          end
        end
        default: res_status <= (kind == K_MATCH) ? ST_DONE : ST_MISS;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= res_status;
      hit         <= res_hit;
      found_value <= res_fv;
      found_key   <= res_fk;
      slot        <= res_slot;
      live_count  <= live;
    end
  end

endmodule

>>> src/linear_probe_hash_table.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and tombstones.
// ---------------------------------------------------------------------------
// One request is in flight at a time. Slots live in a single RAM with one
// read and one write port and registered read data, and every slot visited
// is first read, then checked. Clear sweeps all 1024 slots, one per cycle.
// After reset the same clearing pass runs before the first request is
// taken; max_used may be written meanwhile. A finished result waits in an
// output register, and the next request is taken while it waits.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [MAXU_BITS-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_BITS-1:0]    op,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [SLOT_BITS-1:0]  home,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RANK_BITS-1:0]  rank,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_BITS-1:0]  status,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] found_value,
  output logic [KEY_BITS-1:0]   found_key,
  output logic [SLOT_BITS-1:0]  slot,
  output logic [CNT_BITS-1:0]   live_count
);

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lpht_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .op          (op),
    .key         (key),
    .home        (home),
    .value       (value),
    .rank        (rank),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .found_value (found_value),
    .found_key   (found_key),
    .slot        (slot),
    .live_count  (live_count)
  );

endmodule

>>> src/lpht_checker.sv
// ---------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the hash table's result channel.
// ---------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_we,
  input logic [MAXU_BITS-1:0]  cfg_data,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [OP_BITS-1:0]    op,
  input logic [KEY_BITS-1:0]   key,
  input logic [SLOT_BITS-1:0]  home,
  input logic [VALUE_BITS-1:0] value,
  input logic [RANK_BITS-1:0]  rank,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STAT_BITS-1:0]  status,
  input logic                  hit,
  input logic [VALUE_BITS-1:0] found_value,
  input logic [KEY_BITS-1:0]   found_key,
  input logic [SLOT_BITS-1:0]  slot,
  input logic [CNT_BITS-1:0]   live_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_value))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DONE) || (status == ST_MISS) || (status == ST_FULL))
    else $error("bad status code");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_DONE)
    else $error("hit without success");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> !hit && (found_value == '0))
    else $error("failed request carries data");

  a_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> live_count <= CNT_BITS'(SLOTS))
    else $error("live count out of range");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
